// ===== src/wwsm_pkg.sv =====
// Package with shared widths, constants and types of the wide-word scale unit.
`timescale 1ns / 1ps

package wwsm_pkg;

  localparam int WORD_COUNT     = 7;
  localparam int WORD_BITS      = 32;
  localparam int VALUE_BITS     = WORD_COUNT * WORD_BITS;
  localparam int FACTOR_BITS    = 31;
  localparam int PASSES_BITS    = 6;
  localparam int BIT_CNT_W      = $clog2(VALUE_BITS);
  localparam int DEF_MAX_PASSES = 63;

  localparam int IN_DATA_BITS   = ((FACTOR_BITS + PASSES_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS  = ((VALUE_BITS + FACTOR_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic first;
    logic mul;
  } ctrl_t;

endpackage

// ===== src/wwsm_shifter.sv =====
// Value shift register that streams one bit per cycle through the arithmetic slice.
`timescale 1ns / 1ps

module wwsm_shifter (
  input  logic                           clk,
  input  wwsm_pkg::ctrl_t                ctl,
  input  logic [wwsm_pkg::VALUE_BITS-1:0] load_value,
  input  logic                           res_bit,
  output logic                           ser_bit,
  output logic [wwsm_pkg::VALUE_BITS-1:0] value
);

  localparam int VB = wwsm_pkg::VALUE_BITS;

  logic [VB-1:0] value_r;
  logic [VB-1:0] value_nxt;

  // Multiply walks the value from the low end, divide from the high end.
  always_comb begin
    value_nxt = value_r;
    if (ctl.load) begin
      value_nxt = load_value;
    end else if (ctl.step) begin
      if (ctl.mul) begin
        value_nxt = {res_bit, value_r[VB-1:1]};
      end else begin
        value_nxt = {value_r[VB-2:0], res_bit};
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign ser_bit = ctl.mul ? value_r[0] : value_r[VB-1];
  assign value   = value_r;

endmodule

// ===== src/wwsm_bit_slice.sv =====
// Bit-serial multiply and restoring divide step with the running carry or remainder.
`timescale 1ns / 1ps

module wwsm_bit_slice (
  input  logic                            clk,
  input  wwsm_pkg::ctrl_t                 ctl,
  input  logic [wwsm_pkg::FACTOR_BITS-1:0] in_factor,
  input  logic                            ser_bit,
  output logic                            res_bit,
  output logic [wwsm_pkg::FACTOR_BITS-1:0] rem
);

  localparam int FB = wwsm_pkg::FACTOR_BITS;

  logic [FB-1:0] factor_r;
  logic [FB-1:0] rem_r;
  logic [FB-1:0] rem_nxt;
  logic [FB-1:0] rem_base;
  logic [FB:0]   acc;
  logic [FB:0]   trial;
  logic          fits;

  // The running carry or remainder starts from zero at the first bit of every pass.
  assign rem_base = ctl.first ? '0 : rem_r;
  assign acc      = {1'b0, rem_base} + (ser_bit ? {1'b0, factor_r} : '0);
  assign trial    = {rem_base, ser_bit};
  assign fits     = trial >= {1'b0, factor_r};

  always_comb begin
    res_bit = 1'b0;
    rem_nxt = rem_r;
    if (ctl.load) begin
      rem_nxt = '0;
    end else if (ctl.step) begin
      if (ctl.mul) begin
        res_bit = acc[0];
        rem_nxt = acc[FB:1];
      end else begin
        res_bit = fits;
        rem_nxt = fits ? FB'(trial - {1'b0, factor_r}) : trial[FB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (ctl.load) begin
      factor_r <= in_factor;
    end
  end

  assign rem = rem_r;

endmodule

// ===== src/wwsm_ctrl.sv =====
// Sequencer that counts bits and passes and hands results to the output register.
`timescale 1ns / 1ps

module wwsm_ctrl #(
  parameter int MAX_PASSES = wwsm_pkg::DEF_MAX_PASSES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_mul,
  input  logic                            in_zero_div,
  input  logic [wwsm_pkg::PASSES_BITS-1:0] in_passes,
  input  logic                            out_free,
  output logic                            in_ready,
  output logic                            out_load,
  output logic                            zero_div,
  output wwsm_pkg::ctrl_t                 ctl
);

  localparam int PW = $clog2(MAX_PASSES + 1);
  localparam int CW = (PW > wwsm_pkg::PASSES_BITS) ? PW : wwsm_pkg::PASSES_BITS;
  localparam int BW = wwsm_pkg::BIT_CNT_W;

  wwsm_pkg::state_t state_r, state_nxt;
  logic [BW-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [PW-1:0]    pass_cnt_r, pass_cnt_nxt;
  logic             mul_r, mul_nxt;
  logic             zdiv_r, zdiv_nxt;
  logic [CW-1:0]    passes_ext;
  logic [CW-1:0]    passes_lim;
  logic             last_bit;
  logic             no_work;

  assign passes_ext = CW'(in_passes);
  assign passes_lim = (passes_ext > CW'(MAX_PASSES)) ? CW'(MAX_PASSES) : passes_ext;
  assign last_bit   = bit_cnt_r == BW'(wwsm_pkg::VALUE_BITS - 1);
  assign no_work    = in_zero_div || (passes_lim == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wwsm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = no_work ? wwsm_pkg::ST_DONE : wwsm_pkg::ST_RUN;
        end
      end
      wwsm_pkg::ST_RUN: begin
        if (last_bit && pass_cnt_r == PW'(1)) begin
          state_nxt = wwsm_pkg::ST_DONE;
        end
      end
      wwsm_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = wwsm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wwsm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    bit_cnt_nxt  = bit_cnt_r;
    pass_cnt_nxt = pass_cnt_r;
    mul_nxt      = mul_r;
    zdiv_nxt     = zdiv_r;
    if (ctl.load) begin
      bit_cnt_nxt  = '0;
      pass_cnt_nxt = PW'(passes_lim);
      mul_nxt      = in_mul;
      zdiv_nxt     = in_zero_div;
    end else if (ctl.step) begin
      if (last_bit) begin
        bit_cnt_nxt  = '0;
        pass_cnt_nxt = pass_cnt_r - PW'(1);
      end else begin
        bit_cnt_nxt = bit_cnt_r + BW'(1);
      end
    end
  end

  always_comb begin
    in_ready  = state_r == wwsm_pkg::ST_IDLE;
    ctl.load  = (state_r == wwsm_pkg::ST_IDLE) && in_valid;
    ctl.step  = state_r == wwsm_pkg::ST_RUN;
    ctl.first = bit_cnt_r == '0;
    ctl.mul   = ctl.load ? in_mul : mul_r;
    out_load  = (state_r == wwsm_pkg::ST_DONE) && out_free;
    zero_div  = zdiv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= wwsm_pkg::ST_IDLE;
      bit_cnt_r  <= '0;
      pass_cnt_r <= '0;
      mul_r      <= 1'b0;
      zdiv_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      pass_cnt_r <= pass_cnt_nxt;
      mul_r      <= mul_nxt;
      zdiv_r     <= zdiv_nxt;
    end
  end

endmodule

// ===== src/wide_word_scale_mul_div.sv =====
// Top level of the 224-bit multiply or divide by a 31-bit factor, repeated over passes.
//
//   Channel   Direction   Handshake              Payload
//   in_       slave       in_tvalid / in_tready   tdata: factor, passes, word_0..6; tuser: action
//   out_      master      out_tvalid / out_tready tdata: out_word_0..6, leftover; tuser: flag
//
// A word runs min(passes, MAX_PASSES) passes, or none when dividing by zero: every
// pass streams the 224 value bits one per cycle through a single 32-bit add or
// compare-subtract slice.
// Reset clears the sequencer and the output valid; the datapath is loaded with each word.
// A finished result waits in the output register, so the next word can be taken and
// computed while the result is held; the sequencer stalls at the end until it is taken.
`timescale 1ns / 1ps

module wide_word_scale_mul_div #(
  parameter int MAX_PASSES = wwsm_pkg::DEF_MAX_PASSES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: factor, passes, word_0 .. word_6, zero fill.
  input  logic [wwsm_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // Fields from bit 0: action.
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: out_word_0 .. out_word_6, leftover, zero fill.
  output logic [wwsm_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // Fields from bit 0: zero_divisor.
  output logic                              out_tuser
);

  localparam int FB = wwsm_pkg::FACTOR_BITS;
  localparam int PB = wwsm_pkg::PASSES_BITS;
  localparam int VB = wwsm_pkg::VALUE_BITS;

  wwsm_pkg::ctrl_t ctl;
  logic [FB-1:0]   in_factor;
  logic [PB-1:0]   in_passes;
  logic [VB-1:0]   in_value;
  logic            in_zero_div;
  logic            ser_bit;
  logic            res_bit;
  logic [VB-1:0]   value;
  logic [FB-1:0]   rem;
  logic            out_free;
  logic            out_load;
  logic            zero_div;

  logic [VB-1:0]   out_value_r;
  logic [FB-1:0]   out_leftover_r;
  logic            out_zdiv_r;
  logic            out_tvalid_r;

  assign in_factor   = in_tdata[FB-1:0];
  assign in_passes   = in_tdata[FB+PB-1:FB];
  assign in_value    = in_tdata[FB+PB+VB-1:FB+PB];
  assign in_zero_div = !in_tuser && (in_factor == '0);
  assign out_free    = !out_tvalid_r || out_tready;

  wwsm_ctrl #(
    .MAX_PASSES (MAX_PASSES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_mul      (in_tuser),
    .in_zero_div (in_zero_div),
    .in_passes   (in_passes),
    .out_free    (out_free),
    .in_ready    (in_tready),
    .out_load    (out_load),
    .zero_div    (zero_div),
    .ctl         (ctl)
  );

  wwsm_shifter u_shifter (
    .clk        (clk),
    .ctl        (ctl),
    .load_value (in_value),
    .res_bit    (res_bit),
    .ser_bit    (ser_bit),
    .value      (value)
  );

  wwsm_bit_slice u_slice (
    .clk       (clk),
    .ctl       (ctl),
    .in_factor (in_factor),
    .ser_bit   (ser_bit),
    .res_bit   (res_bit),
    .rem       (rem)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r    <= value;
      out_leftover_r <= rem;
      out_zdiv_r     <= zero_div;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(wwsm_pkg::OUT_DATA_BITS - VB - FB){1'b0}}, out_leftover_r, out_value_r};
  assign out_tuser  = out_zdiv_r;

endmodule
